// ===== rtl/core/silence_and_stuck_energy_monitor_assert.svh =====
// assertion macros shared by the monitor's checker
// no dependencies; included by name from the checker file
`ifndef SILENCE_AND_STUCK_ENERGY_MONITOR_ASSERT_SVH
`define SILENCE_AND_STUCK_ENERGY_MONITOR_ASSERT_SVH

// same-cycle implication, idle while rst is high
`define SMON_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("smon assertion failed");

// next-cycle implication, idle while rst is high
`define SMON_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("smon assertion failed");

`endif

// ===== rtl/core/smon_pkg.sv =====
// shared types and constants for the silence and stuck energy monitor
// no dependencies; imported by every module of the block
package smon_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int RUN_BITS    = 16;
   localparam int THRESH_BITS = 16;
   localparam int LIMIT_BITS  = 16;
   localparam int PHASE_BITS  = 8;
   localparam int REPEAT_BITS = 4;
   localparam int EVENT_BITS  = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   // common widths for the run and peak compares
   localparam int RUN_CMP_BITS  = (RUN_BITS > THRESH_BITS) ? RUN_BITS : THRESH_BITS;
   localparam int PEAK_CMP_BITS = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;

   localparam logic [PHASE_BITS-1:0]  PHASE_HIT    = 8'h80;
   localparam logic [REPEAT_BITS-1:0] REPEAT_LIMIT = 4'd10;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SILENCE_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_QUIET_PEAK_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STUCK_CHECK_ENABLE = 2'd2;

   localparam logic [THRESH_BITS-1:0]       SILENCE_THRESHOLD_RST = 16'd500;
   localparam logic signed [LIMIT_BITS-1:0] QUIET_PEAK_LIMIT_RST  = 16'sd5;

   typedef enum logic [EVENT_BITS-1:0] {
      EVENT_NONE   = 2'd0,
      EVENT_PAUSE  = 2'd1,
      EVENT_RESUME = 2'd2
   } play_event_type;

   typedef struct packed {
      logic                          energy_valid;
      logic signed [SAMPLE_BITS-1:0] frame_mean;
      logic signed [SAMPLE_BITS-1:0] energy_peak;
   } report_type;

   typedef struct packed {
      play_event_type play_event;
      logic           reset_request;
   } result_type;

   typedef struct packed {
      logic [THRESH_BITS-1:0]       silence_threshold;
      logic signed [LIMIT_BITS-1:0] quiet_peak_limit;
      logic                         stuck_check_enable;
   } cfg_type;

endpackage

// ===== rtl/core/smon_in_reg.sv =====
// input register of the monitor: holds one accepted report
// depends on smon_pkg
module smon_in_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_energy_valid,
   input  logic [smon_pkg::SAMPLE_BITS-1:0] req_frame_mean,
   input  logic [smon_pkg::SAMPLE_BITS-1:0] req_energy_peak,
   input  logic                          advance,
   output logic                          pending,
   output smon_pkg::report_type          report
);
   import smon_pkg::*;

   logic       pend_ff, pend_in;
   report_type report_ff, report_in;
   logic       take;

   assign req_ready = !pend_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      pend_in   = pend_ff;
      report_in = report_ff;
      if (take) begin
         pend_in                = 1'b1;
         report_in.energy_valid = req_energy_valid;
         report_in.frame_mean   = req_frame_mean;
         report_in.energy_peak  = req_energy_peak;
      end else if (advance) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      report_ff <= report_in;
   end

   assign pending = pend_ff;
   assign report  = report_ff;

endmodule

// ===== rtl/core/smon_track.sv =====
// quiet run, stuck sample and halt state with the per-report decision logic
// depends on smon_pkg
module smon_track (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  smon_pkg::report_type report,
   input  smon_pkg::cfg_type    cfg,
   output smon_pkg::result_type result
);
   import smon_pkg::*;

   logic [PHASE_BITS-1:0]  tick_phase_ff, tick_phase_in;
   logic [RUN_BITS-1:0]    quiet_run_ff, quiet_run_in;
   logic [SAMPLE_BITS-1:0] last_mean_ff, last_mean_in;
   logic [SAMPLE_BITS-1:0] last_peak_ff, last_peak_in;
   logic [REPEAT_BITS-1:0] repeat_run_ff, repeat_run_in;
   logic                   halted_ff, halted_in;

   logic                   active;
   logic [PHASE_BITS-1:0]  phase_next;
   logic [REPEAT_BITS-1:0] repeat_next;
   logic [RUN_BITS-1:0]    run_inc;
   logic                   sample_hit, match, halt_now, quiet;
   logic signed [PEAK_CMP_BITS-1:0] peak_cmp, limit_cmp;
   logic [RUN_CMP_BITS-1:0] run_inc_cmp, run_cmp, thresh_cmp;
   play_event_type          event_code;

   assign active      = !halted_ff && report.energy_valid;
   assign phase_next  = tick_phase_ff + 8'd1;
   assign repeat_next = repeat_run_ff + 4'd1;
   assign run_inc     = quiet_run_ff + RUN_BITS'(1);
   assign sample_hit  = cfg.stuck_check_enable && (phase_next == PHASE_HIT);

   // negative samples never match the stored value
   assign match = !report.frame_mean[SAMPLE_BITS-1] && !report.energy_peak[SAMPLE_BITS-1]
                  && (report.frame_mean == last_mean_ff)
                  && (report.energy_peak == last_peak_ff)
                  && (last_mean_ff != '0);
   assign halt_now = sample_hit && match && (repeat_next == REPEAT_LIMIT);

   assign peak_cmp  = $signed(report.energy_peak);
   assign limit_cmp = $signed(cfg.quiet_peak_limit);
   assign quiet     = (report.frame_mean == '0) && (peak_cmp < limit_cmp);

   assign run_inc_cmp = RUN_CMP_BITS'(run_inc);
   assign run_cmp     = RUN_CMP_BITS'(quiet_run_ff);
   assign thresh_cmp  = RUN_CMP_BITS'(cfg.silence_threshold);

   always_comb begin
      tick_phase_in = tick_phase_ff;
      quiet_run_in  = quiet_run_ff;
      last_mean_in  = last_mean_ff;
      last_peak_in  = last_peak_ff;
      repeat_run_in = repeat_run_ff;
      halted_in     = halted_ff;
      event_code    = EVENT_NONE;
      if (active) begin
         if (cfg.stuck_check_enable) begin
            tick_phase_in = phase_next;
         end
         if (sample_hit) begin
            if (match) begin
               repeat_run_in = repeat_next;
               if (halt_now) begin
                  halted_in = 1'b1;
               end
            end else begin
               repeat_run_in = '0;
               last_mean_in  = report.frame_mean;
               last_peak_in  = report.energy_peak;
            end
         end
         if (!halt_now) begin
            if (quiet) begin
               if (!(&quiet_run_ff)) begin
                  quiet_run_in = run_inc;
                  if (run_inc_cmp == thresh_cmp) begin
                     event_code = EVENT_PAUSE;
                  end
               end
            end else begin
               if (run_cmp >= thresh_cmp) begin
                  event_code = EVENT_RESUME;
               end
               quiet_run_in = '0;
            end
         end
      end
   end

   assign result.play_event    = event_code;
   assign result.reset_request = halted_ff || (active && halt_now);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_phase_ff <= '0;
         quiet_run_ff  <= '0;
         last_mean_ff  <= '0;
         last_peak_ff  <= '0;
         repeat_run_ff <= '0;
         halted_ff     <= 1'b0;
      end else if (advance) begin
         tick_phase_ff <= tick_phase_in;
         quiet_run_ff  <= quiet_run_in;
         last_mean_ff  <= last_mean_in;
         last_peak_ff  <= last_peak_in;
         repeat_run_ff <= repeat_run_in;
         halted_ff     <= halted_in;
      end
   end

endmodule

// ===== rtl/core/smon_out_reg.sv =====
// result register of the monitor: holds one result until taken
// depends on smon_pkg
module smon_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  smon_pkg::result_type result,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [smon_pkg::EVENT_BITS-1:0] rsp_play_event,
   output logic                 rsp_reset_request
);
   import smon_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_play_event    = result_ff.play_event;
   assign rsp_reset_request = result_ff.reset_request;

endmodule

// ===== rtl/core/silence_and_stuck_energy_monitor.sv =====
// top level of the silence and stuck energy monitor
// depends on smon_pkg, smon_in_reg, smon_track and smon_out_reg
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------
//   req      | in        | req_valid/req_ready  | energy_valid, frame_mean, energy_peak
//   rsp      | out       | rsp_valid/rsp_ready  | play_event, reset_request
//   csr      | in        | csr_write_enable     | csr_index, csr_write_data
//
// one item per cycle sustained while rsp is not stalled; the result is offered on rsp
// once the item has passed from the input register through the decision logic into the result register
// reset: synchronous, clears handshake state, the three registers to their defaults
// and all tracking state; the halt is cleared only by reset
// a stalled rsp holds the result register, the input register fills behind it
// and req_ready drops only when both are occupied
module silence_and_stuck_energy_monitor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_energy_valid,
   input  logic [smon_pkg::SAMPLE_BITS-1:0]  req_frame_mean,
   input  logic [smon_pkg::SAMPLE_BITS-1:0]  req_energy_peak,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [smon_pkg::EVENT_BITS-1:0]   rsp_play_event,
   output logic                              rsp_reset_request,
   input  logic                              csr_write_enable,
   input  logic [smon_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [smon_pkg::CSR_DATA_BITS-1:0] csr_write_data
);
   import smon_pkg::*;

   // configuration registers
   cfg_type    cfg_ff, cfg_in;

   // pipeline hand-over
   logic       pending;
   logic       out_free;
   logic       advance;
   report_type report;
   result_type result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SILENCE_THRESHOLD:  cfg_in.silence_threshold  = csr_write_data;
            CSR_QUIET_PEAK_LIMIT:   cfg_in.quiet_peak_limit   = csr_write_data;
            CSR_STUCK_CHECK_ENABLE: cfg_in.stuck_check_enable = csr_write_data[0];
            default:                cfg_in = cfg_ff;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.silence_threshold  <= SILENCE_THRESHOLD_RST;
         cfg_ff.quiet_peak_limit   <= QUIET_PEAK_LIMIT_RST;
         cfg_ff.stuck_check_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // an item leaves the input register when the result register can take it
   assign advance = pending && out_free;

   smon_in_reg u_in_reg (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_energy_valid (req_energy_valid),
      .req_frame_mean   (req_frame_mean),
      .req_energy_peak  (req_energy_peak),
      .advance          (advance),
      .pending          (pending),
      .report           (report)
   );

   // state commits on the same edge that loads the result
   smon_track u_track (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .report (report),
      .cfg    (cfg_ff),
      .result (result)
   );

   smon_out_reg u_out_reg (
      .clock             (clock),
      .reset             (reset),
      .load              (advance),
      .result            (result),
      .free              (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_play_event    (rsp_play_event),
      .rsp_reset_request (rsp_reset_request)
   );

endmodule

// ===== rtl/core/smon_checker.sv =====
// port-level checks for the silence and stuck energy monitor, bound to the top level
// depends on smon_pkg and silence_and_stuck_energy_monitor_assert.svh
`include "silence_and_stuck_energy_monitor_assert.svh"

module smon_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [smon_pkg::EVENT_BITS-1:0] rsp_play_event,
   input logic                            rsp_reset_request
);
   import smon_pkg::*;

   // a reset request item never also carries an event
   `SMON_ASSERT_IMPLY(a_request_no_event, clock, reset, rsp_valid && rsp_reset_request, rsp_play_event == EVENT_NONE)

   // once a request is delivered, an item offered straight after it keeps it
   `SMON_ASSERT_NEXT(a_request_sticky, clock, reset, rsp_valid && rsp_ready && rsp_reset_request, !rsp_valid || rsp_reset_request)

   // nothing is offered straight after reset
   `SMON_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)

   // a stalled result holds
   `SMON_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_play_event) && $stable(rsp_reset_request))

endmodule

bind silence_and_stuck_energy_monitor smon_checker u_smon_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_play_event    (rsp_play_event),
   .rsp_reset_request (rsp_reset_request)
);
